FILE: hw/rtl/sstk_pkg.sv
// ---------------------------------------------------------------------------
// sstk_pkg
// Shared types, opcodes, status codes and default sizes for the segmented
// stack block.
// ---------------------------------------------------------------------------
package sstk_pkg;

    // default sizes
    localparam int NUM_SEGMENTS_DEF  = 8;
    localparam int SEGMENT_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF   = 32;

    // capacity register
    localparam int         CAP_W         = 5;
    localparam logic [4:0] CAPACITY_RESET = 5'd10;

    // opcodes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_POP_AT = 2'd2;
    localparam logic [1:0] OP_TOP    = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // read-top value of an empty stack
    localparam logic signed [31:0] EMPTY_TOP = -32'sd1;

    // command beat
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] push_value;
        logic [2:0]         segment_index;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic signed [31:0] top_value;
        logic [1:0]         status;
        logic               is_empty;
    } result_t;

endpackage

FILE: hw/rtl/sstk_ram.sv
// ---------------------------------------------------------------------------
// sstk_ram
// Simple dual-port value memory: one write port, one read port with a
// registered read. Contents are not reset.
// ---------------------------------------------------------------------------
module sstk_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/segmented_stack_with_pop_at_top.sv
// Sequence: a command beat is taken in idle; push and pop-at finish in the execute state;
//   pop and read-top first skip the empty top segments there, one per cycle by
//   decrementing the segment pointer, and read-top then reads the value memory.
// Commands: busy is high outside idle, and a new command is taken only in idle;
//   read-top adds a state for the registered read of the value memory. done pulses for one cycle.
// Reset: fill counts, segment pointer and capacity (10) clear at once; the
//   value memory is not cleared. The receiver cannot hold results off.
// ---------------------------------------------------------------------------
// segmented_stack_with_pop_at_top
// Stack kept as a set of fixed-size segments in one value memory, with push,
// pop, pop from a named segment and read-top.
// ---------------------------------------------------------------------------
module segmented_stack_with_pop_at_top
    import sstk_pkg::*;
#(
    parameter int NUM_SEGMENTS  = NUM_SEGMENTS_DEF,
    parameter int SEGMENT_DEPTH = SEGMENT_DEPTH_DEF,
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int SEG_W   = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int CMP_W   = (SEG_W > 3) ? SEG_W + 1 : 4;
    localparam int FILL_W  = $clog2(SEGMENT_DEPTH + 1);
    localparam int CW      = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int DEPTH   = NUM_SEGMENTS * SEGMENT_DEPTH;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [2:0]         idx_reg;
    logic [SEG_W-1:0]   cur_reg, cur_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [CAP_W-1:0]   cap_reg;
    logic               done_reg, done_next;
    result_t            res_reg, res_next;
    logic [FILL_W-1:0]  fill_reg [NUM_SEGMENTS];

    // fill count write request
    logic               fill_we;
    logic [SEG_W-1:0]   fill_wr_idx;
    logic [FILL_W-1:0]  fill_wr_val;

    // value memory ports
    logic                   mem_we, mem_re;
    logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

    // decode helpers
    logic [CMP_W-1:0]   idx_ext, cur_ext;
    logic               idx_ok;
    logic [SEG_W-1:0]   fill_addr;
    logic [FILL_W-1:0]  fill_rd;
    logic [CW-1:0]      eff_cap;
    logic               seg_full;
    logic               can_open;
    logic [SEG_W-1:0]   cur_inc;
    logic signed [63:0] push_wide;
    logic signed [63:0] read_wide;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

    // pop-at segment check and shared fill-count read
    assign idx_ext   = CMP_W'(idx_reg);
    assign cur_ext   = CMP_W'(cur_reg);
    assign idx_ok    = (idx_ext <= cur_ext) && (idx_ext < CMP_W'(NUM_SEGMENTS));
    assign fill_addr = (op_reg == OP_POP_AT && idx_ok) ? idx_ext[SEG_W-1:0] : cur_reg;
    assign fill_rd   = fill_reg[fill_addr];

    // capacity clamped to one..segment depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CW'(1);
        end
        else if (CW'(cap_reg) > CW'(SEGMENT_DEPTH))
        begin
            eff_cap = CW'(SEGMENT_DEPTH);
        end
        else
        begin
            eff_cap = CW'(cap_reg);
        end
    end

    assign seg_full  = (CW'(fill_rd) >= eff_cap);
    assign can_open  = ((SEG_W + 1)'(cur_reg) + (SEG_W + 1)'(1)) < (SEG_W + 1)'(NUM_SEGMENTS);
    assign cur_inc   = cur_reg + SEG_W'(1);
    assign push_wide = 64'(val_reg);
    assign read_wide = 64'($signed(mem_rdata));

    // command sequencing
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        total_next  = total_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        fill_we     = 1'b0;
        fill_wr_idx = cur_reg;
        fill_wr_val = fill_rd;
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(cur_reg) * ADDR_W'(SEGMENT_DEPTH) + ADDR_W'(fill_rd);
        mem_wdata   = push_wide[VALUE_WIDTH-1:0];
        mem_re      = 1'b0;
        mem_raddr   = ADDR_W'(cur_reg) * ADDR_W'(SEGMENT_DEPTH)
                      + ADDR_W'(fill_rd) - ADDR_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next.top_value = '0;
                res_next.status    = ST_DONE;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (!seg_full)
                        begin
                            mem_we      = 1'b1;
                            fill_we     = 1'b1;
                            fill_wr_val = fill_rd + FILL_W'(1);
                            total_next  = total_reg + TOT_W'(1);
                        end
                        else if (can_open)
                        begin
                            // open the next segment with this value at its base
                            cur_next    = cur_inc;
                            mem_we      = 1'b1;
                            mem_waddr   = ADDR_W'(cur_inc) * ADDR_W'(SEGMENT_DEPTH);
                            fill_we     = 1'b1;
                            fill_wr_idx = cur_inc;
                            fill_wr_val = FILL_W'(1);
                            total_next  = total_reg + TOT_W'(1);
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                        end
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    OP_POP_AT:
                    begin
                        if (!idx_ok || fill_rd == '0)
                        begin
                            res_next.status = ST_IGNORED;
                        end
                        else
                        begin
                            fill_we     = 1'b1;
                            fill_wr_idx = fill_addr;
                            fill_wr_val = fill_rd - FILL_W'(1);
                            total_next  = total_reg - TOT_W'(1);
                        end
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    default:
                    begin
                        // pop and read-top: skip empty top segments first
                        if (cur_reg != '0 && fill_rd == '0)
                        begin
                            cur_next = cur_reg - SEG_W'(1);
                        end
                        else if (fill_rd == '0)
                        begin
                            res_next.status = ST_IGNORED;
                            if (op_reg == OP_TOP)
                            begin
                                res_next.top_value = EMPTY_TOP;
                            end
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                        else if (op_reg == OP_POP)
                        begin
                            fill_we     = 1'b1;
                            fill_wr_val = fill_rd - FILL_W'(1);
                            total_next  = total_reg - TOT_W'(1);
                            state_next  = S_IDLE;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end
                endcase
                res_next.is_empty = (total_next == '0);
            end
            S_READ:
            begin
                // top value back from the memory
                res_next.top_value = read_wide[31:0];
                res_next.status    = ST_DONE;
                res_next.is_empty  = (total_reg == '0);
                state_next         = S_IDLE;
                done_next          = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
            cap_reg   <= CAPACITY_RESET;
            for (int i = 0; i < NUM_SEGMENTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            total_reg <= total_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (fill_we)
            begin
                fill_reg[fill_wr_idx] <= fill_wr_val;
            end
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == S_IDLE && start)
        begin
            op_reg  <= cmd.opcode;
            val_reg <= cmd.push_value;
            idx_reg <= cmd.segment_index;
        end
    end

    // value memory
    sstk_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segmented stack. Commands go in over the
// start/busy handshake while a behavioural copy of the stack predicts each
// result beat. A monitor checks every done beat against the oldest
// prediction. Directed cases cover the empty stack, value extremes and a
// capacity of one. Random traffic then runs under several capacity settings and
// sender idle rates.
// ---------------------------------------------------------------------------
module tb_top;
    import sstk_pkg::*;

    localparam int SEG_COUNT = NUM_SEGMENTS_DEF;
    localparam int SEG_DEPTH = SEGMENT_DEPTH_DEF;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // block ports
    logic       start = 1'b0;
    logic       busy;
    cmd_t       cmd = '0;
    logic       done;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data = '0;

    // behavioural copy of the stack
    logic [31:0] value_mem [0:SEG_COUNT*SEG_DEPTH-1];
    int unsigned seg_fill [0:SEG_COUNT-1];
    int unsigned open_seg;
    logic [4:0]  capacity_reg;

    // predicted result beats, oldest first
    result_t pending_results [$];
    result_t want_result;

    // sender idle rate in percent of cycles
    int unsigned idle_pct = 0;

    // run statistics
    int unsigned error_count = 0;
    int unsigned results_checked = 0;
    int unsigned op_count [0:3] = '{0, 0, 0, 0};
    int unsigned full_count = 0;
    int unsigned ignored_count = 0;
    int unsigned cfg_writes = 0;

    always #5 clk = ~clk;

    segmented_stack_with_pop_at_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // one line per mismatch, printing capped to keep the log short
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // discard empty top segments, down to segment 0 at the lowest
    function automatic void drop_empty_segments();
        while (open_seg > 0 && seg_fill[open_seg] == 0)
            open_seg--;
    endfunction

    // apply one command to the stack copy and return its result beat
    function automatic result_t stack_apply(input cmd_t c);
        result_t     r;
        int unsigned cap_eff;
        int unsigned seg;
        r = '0;
        r.status = ST_DONE;
        cap_eff = capacity_reg;
        if (cap_eff < 1)
            cap_eff = 1;
        if (cap_eff > SEG_DEPTH)
            cap_eff = SEG_DEPTH;
        case (c.opcode)
            OP_PUSH:
            begin
                seg = open_seg;
                if (seg_fill[seg] >= cap_eff)
                begin
                    if (seg + 1 < SEG_COUNT)
                    begin
                        seg++;
                        seg_fill[seg] = 0;
                        open_seg = seg;
                    end
                    else
                        r.status = ST_FULL;
                end
                if (r.status == ST_DONE)
                begin
                    value_mem[seg*SEG_DEPTH + seg_fill[seg]] = c.push_value;
                    seg_fill[seg]++;
                end
            end
            OP_POP:
            begin
                drop_empty_segments();
                if (seg_fill[open_seg] == 0)
                    r.status = ST_IGNORED;
                else
                    seg_fill[open_seg]--;
            end
            OP_POP_AT:
            begin
                if (c.segment_index > open_seg || c.segment_index >= SEG_COUNT ||
                    seg_fill[c.segment_index] == 0)
                    r.status = ST_IGNORED;
                else
                    seg_fill[c.segment_index]--;
            end
            default:
            begin
                drop_empty_segments();
                if (seg_fill[open_seg] == 0)
                begin
                    r.status = ST_IGNORED;
                    r.top_value = EMPTY_TOP;
                end
                else
                    r.top_value = value_mem[open_seg*SEG_DEPTH + seg_fill[open_seg] - 1];
            end
        endcase
        r.is_empty = 1'b1;
        for (int s = 0; s < SEG_COUNT; s++)
            if (seg_fill[s] != 0)
                r.is_empty = 1'b0;
        return r;
    endfunction

    // send one command beat, with random sender idling ahead of it
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] val,
                            input logic [2:0] idx);
        cmd_t    c;
        result_t r;
        c.opcode = op;
        c.push_value = val;
        c.segment_index = idx;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        r = stack_apply(c);
        op_count[op]++;
        if (r.status == ST_FULL)
            full_count++;
        if (r.status == ST_IGNORED)
            ignored_count++;
        pending_results = {pending_results, r};
    endtask

    // stop sending and wait until every predicted beat has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0 || busy);
    endtask

    // capacity register write, only with the block idle
    task automatic write_capacity(input logic [4:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity_reg = v;
        cfg_writes++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result beat: top %0d status %0d",
                                          result.top_value, result.status));
            else
            begin
                want_result = pending_results.pop_front();
                results_checked++;
                if (result.top_value !== want_result.top_value)
                    report_mismatch($sformatf("top_value %0d, expected %0d",
                                              result.top_value, want_result.top_value));
                if (result.status !== want_result.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result.status, want_result.status));
                if (result.is_empty !== want_result.is_empty)
                    report_mismatch($sformatf("is_empty %0b, expected %0b",
                                              result.is_empty, want_result.is_empty));
            end
        end
    end

    // read-top, pop and pop-at on an empty stack are all ignored
    task automatic test_empty_stack();
        send_cmd(OP_TOP, 32'h0, 3'd0);
        send_cmd(OP_POP, 32'h0, 3'd0);
        send_cmd(OP_POP_AT, 32'h0, 3'd0);
        send_cmd(OP_POP_AT, 32'h0, 3'd7);
    endtask

    // extreme values through push, read-top and both pops
    task automatic test_value_extremes();
        send_cmd(OP_PUSH, 32'h7FFF_FFFF, 3'd0);
        send_cmd(OP_PUSH, 32'h8000_0000, 3'd0);
        send_cmd(OP_TOP, 32'h0, 3'd0);
        send_cmd(OP_POP, 32'h0, 3'd0);
        send_cmd(OP_TOP, 32'h0, 3'd0);
        send_cmd(OP_POP_AT, 32'hFFFF_FFFF, 3'd0);
        send_cmd(OP_POP, 32'h0, 3'd0);
        send_cmd(OP_PUSH, 32'hFFFF_FFFF, 3'd7);
        send_cmd(OP_PUSH, 32'h0, 3'd0);
        send_cmd(OP_TOP, 32'h0, 3'd0);
    endtask

    // capacity of one: fill every segment, then hollow
    // out segments so that pop and read-top skip empty ones
    task automatic test_capacity_one();
        write_capacity(5'd1);
        repeat (8)
            send_cmd(OP_PUSH, $urandom, 3'($urandom));
        send_cmd(OP_POP_AT, 32'h0, 3'd3);
        send_cmd(OP_POP_AT, 32'h0, 3'd3);
        send_cmd(OP_POP_AT, 32'h0, 3'd7);
        send_cmd(OP_POP, 32'h0, 3'd0);
        send_cmd(OP_TOP, 32'h0, 3'd0);
        send_cmd(OP_PUSH, $urandom, 3'd0);
    endtask

    // random commands under one capacity and idle setting
    task automatic run_random_phase(input logic [4:0] cap, input int unsigned idle,
                                    input int unsigned push_pct, input int unsigned n);
        int unsigned pick;
        logic [1:0]  op;
        logic [31:0] val;
        logic [2:0]  idx;
        write_capacity(cap);
        idle_pct = idle;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < push_pct)
                op = OP_PUSH;
            else
                case ($urandom_range(2))
                    0: op = OP_POP;
                    1: op = OP_POP_AT;
                    default: op = OP_TOP;
                endcase
            case ($urandom_range(7))
                0: val = 32'h7FFF_FFFF;
                1: val = 32'h8000_0000;
                2: val = 32'hFFFF_FFFF;
                3: val = 32'h0;
                default: val = $urandom;
            endcase
            // pop-at mostly aims at a live segment
            if ($urandom_range(9) < 7)
                idx = 3'($urandom_range(open_seg));
            else
                idx = 3'($urandom);
            send_cmd(op, val, idx);
        end
        idle_pct = 0;
    endtask

    // random traffic across capacities, idle rates and push biases
    task automatic test_random_traffic();
        run_random_phase(5'd16, 0, 70, 150);
        run_random_phase(5'd1, 47, 50, 150);
        run_random_phase(5'd31, 6, 65, 150);
        run_random_phase(5'd0, 0, 40, 150);
        run_random_phase(5'($urandom_range(15, 2)), 47, 75, 150);
        run_random_phase(5'd10, 6, 30, 150);
    endtask

    // main sequence
    initial
    begin
        for (int s = 0; s < SEG_COUNT; s++)
            seg_fill[s] = 0;
        open_seg = 0;
        capacity_reg = CAPACITY_RESET;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_value_extremes();
        test_capacity_one();
        test_random_traffic();

        drain_results();
        repeat (20)
            @(posedge clk);

        $display("ran %0d commands: %0d push, %0d pop, %0d pop-at, %0d read-top; %0d beats checked",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[0],
                 op_count[1], op_count[2], op_count[3], results_checked);
        $display("%0d pushes dropped as full, %0d commands ignored, %0d capacity writes",
                 full_count, ignored_count, cfg_writes);
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/sstk_pkg.sv
hw/rtl/sstk_ram.sv
hw/rtl/segmented_stack_with_pop_at_top.sv
sim/tb_top.sv
